// File: rtl/fpsp_pkg.sv
// fpsp_pkg: shared constants, codes and types for the framed position to stepper pulse block
// used by every rtl file of the block and by its port checker
// no dependencies
package fpsp_pkg;

  // averaging ring and frame sync
  localparam int AVG_DEPTH   = 10;
  localparam int SYNC_COUNT  = 2;
  localparam int FRAME_BYTES = 6;
  localparam int NUM_AXES    = 3;
  localparam int AX_X        = 0;
  localparam int AX_Y        = 1;

  // field and state widths
  localparam int BYTE_W  = 8;
  localparam int POS_W   = 16;
  localparam int DIV_W   = POS_W + 1;
  localparam int TOG_W   = DIV_W + 1;
  localparam int TIME_W  = 32;
  localparam int SPEED_W = 16;
  localparam int SYNC_W  = 2;
  localparam int IDX_W   = $clog2(FRAME_BYTES);
  localparam int SLOT_W  = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;

  // frame time is the ring sum over this divisor
  localparam int FRAME_DIV = 20;
  localparam int DIV20_W   = DIV_W + $clog2(FRAME_DIV);
  localparam int PROD_W    = TIME_W + DIV20_W;
  localparam int SUM_W     = TIME_W + $clog2(AVG_DEPTH);
  localparam int THR_W     = SUM_W + 1;

  // stream and register port shapes
  localparam int IN_DATA_W  = BYTE_W;
  localparam int OUT_DATA_W = 8;
  localparam int DONE_BIT   = 2 * NUM_AXES;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [SYNC_W-1:0]  SYNC_MAX       = 2'd3;
  localparam logic [BYTE_W-1:0]  SYNC_BYTE      = 8'hFF;
  localparam logic [SPEED_W-1:0] SPEED_RESET    = 16'd2000;
  localparam logic [TIME_W-1:0]  INTERVAL_RESET = 32'd66666;

  typedef enum logic {
    KIND_BYTE = 1'b0,
    KIND_TICK = 1'b1
  } kind_t;

  typedef enum logic {
    REG_SPEED_LIMIT      = 1'b0,
    REG_INITIAL_INTERVAL = 1'b1
  } reg_sel_t;

  // per-axis values loaded when a frame completes
  typedef struct packed {
    logic [TOG_W-1:0]   toggles;
    logic [DIV20_W-1:0] div20;
    logic               dir;
  } axis_load_t;

  // per-axis levels after the current item
  typedef struct packed {
    logic step;
    logic dir;
  } axis_out_t;

endpackage

// File: rtl/fpsp_frame.sv
// fpsp_frame: byte parser, frame math and interval averaging ring
// produces per-axis load values and the toggle threshold
// depends on fpsp_pkg
module fpsp_frame import fpsp_pkg::*; (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          byte_valid,
  input  logic                          tick,
  input  logic [BYTE_W-1:0]             data_byte,
  input  logic [SPEED_W-1:0]            speed_limit,
  input  logic                          interval_wr,
  input  logic [TIME_W-1:0]             interval_value,
  output logic                          frame_done,
  output axis_load_t [NUM_AXES-1:0]     axis_load,
  output logic [THR_W-1:0]              thr
);

  localparam logic [THR_W-1:0] THR_BIAS  = THR_W'(FRAME_DIV - 1);
  localparam logic [THR_W-1:0] SM_RESET  =
    THR_W'(AVG_DEPTH) * THR_W'(INTERVAL_RESET) - THR_BIAS;
  localparam logic [THR_W-1:0] THR_RESET = '0 - THR_BIAS;

  logic [SYNC_W-1:0] sync_r, sync_nxt, sync_inc;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [BYTE_W-1:0] bytes_r [FRAME_BYTES-1];
  logic [POS_W-1:0]  prior_r [NUM_AXES];
  logic [TIME_W-1:0] frame_el_r;
  logic [TIME_W-1:0] ring_r [AVG_DEPTH];
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [THR_W-1:0]  sm_r, sm_frame, sm_load;
  logic [THR_W-1:0]  thr_r;

  logic is_sync, resync, last_byte, over_limit;
  logic [FRAME_BYTES*BYTE_W-1:0] frame_word;
  logic [POS_W-1:0] pos   [NUM_AXES];
  logic [POS_W:0]   delta [NUM_AXES];
  logic [POS_W:0]   absd  [NUM_AXES];
  logic [DIV_W-1:0] mag   [NUM_AXES];
  logic [DIV_W-1:0] div   [NUM_AXES];

  // sync run and byte position
  always_comb begin
    is_sync    = data_byte == SYNC_BYTE;
    sync_inc   = (sync_r < SYNC_MAX) ? sync_r + 1'b1 : sync_r;
    resync     = is_sync && (sync_inc >= SYNC_W'(SYNC_COUNT));
    last_byte  = idx_r == IDX_W'(FRAME_BYTES - 1);
    frame_done = byte_valid && !resync && last_byte;
    sync_nxt   = is_sync ? sync_inc : '0;
    idx_nxt    = (resync || last_byte) ? '0 : idx_r + 1'b1;
  end

  // frame word, first byte highest; the current byte closes it
  always_comb begin
    for (int i = 0; i < FRAME_BYTES - 1; i++) begin
      frame_word[(FRAME_BYTES-1-i)*BYTE_W +: BYTE_W] = bytes_r[i];
    end
    frame_word[BYTE_W-1:0] = data_byte;
  end

  // deltas, magnitudes and directions; x travels double
  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      pos[a]   = frame_word[(NUM_AXES-1-a)*POS_W +: POS_W];
      delta[a] = {1'b0, prior_r[a]} - {1'b0, pos[a]};
      absd[a]  = delta[a][POS_W] ? (~delta[a] + 1'b1) : delta[a];
      mag[a]   = (a == AX_X) ? {absd[a][POS_W-1:0], 1'b0} : {1'b0, absd[a][POS_W-1:0]};
    end
  end

  // speed limit caps only the x and y divisors
  always_comb begin
    over_limit = (mag[AX_X] > DIV_W'(speed_limit)) || (mag[AX_Y] > DIV_W'(speed_limit));
    for (int a = 0; a < NUM_AXES; a++) begin
      div[a] = (over_limit && (a == AX_X || a == AX_Y)) ? DIV_W'(speed_limit) : mag[a];
      axis_load[a].toggles = {mag[a], 1'b0};
      axis_load[a].div20   = DIV20_W'(div[a]) * DIV20_W'(FRAME_DIV);
      axis_load[a].dir     = delta[a][POS_W];
    end
  end

  // running ring sum kept less the bias, so the frame time compare needs no divide
  always_comb begin
    sm_frame = sm_r - THR_W'(ring_r[slot_r]) + THR_W'(frame_el_r);
    sm_load  = THR_W'(AVG_DEPTH) * THR_W'(interval_value) - THR_BIAS;
    slot_nxt = (slot_r == SLOT_W'(AVG_DEPTH - 1)) ? '0 : slot_r + 1'b1;
  end

  assign thr = thr_r;

  // control and averaging state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_r     <= '0;
      idx_r      <= '0;
      frame_el_r <= '0;
      slot_r     <= '0;
      sm_r       <= SM_RESET;
      thr_r      <= THR_RESET;
      for (int a = 0; a < NUM_AXES; a++) begin
        prior_r[a] <= '0;
      end
      for (int i = 0; i < AVG_DEPTH; i++) begin
        ring_r[i] <= INTERVAL_RESET;
      end
    end else begin
      if (tick) begin
        frame_el_r <= frame_el_r + 1'b1;
      end
      if (byte_valid) begin
        sync_r <= sync_nxt;
        idx_r  <= idx_nxt;
      end
      if (frame_done) begin
        for (int a = 0; a < NUM_AXES; a++) begin
          prior_r[a] <= pos[a];
        end
        ring_r[slot_r] <= frame_el_r;
        frame_el_r     <= '0;
        slot_r         <= slot_nxt;
        sm_r           <= sm_frame;
        thr_r          <= sm_frame;
      end
      if (interval_wr) begin
        for (int i = 0; i < AVG_DEPTH; i++) begin
          ring_r[i] <= interval_value;
        end
        sm_r <= sm_load;
      end
    end
  end

  // frame bytes, undefined until written
  always_ff @(posedge clk) begin
    if (byte_valid && !resync && !last_byte) begin
      bytes_r[idx_r] <= data_byte;
    end
  end

endmodule

// File: rtl/fpsp_axis.sv
// fpsp_axis: step timing for one axis, toggled on microsecond ticks
// compares elapsed time times twenty times divisor against the ring threshold
// depends on fpsp_pkg
module fpsp_axis import fpsp_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             tick,
  input  logic             load,
  input  axis_load_t       load_val,
  input  logic [THR_W-1:0] thr,
  output axis_out_t        axis_out
);

  // elapsed time as it will stand at the next tick
  logic [TIME_W-1:0]  e1_r, e1_nxt;
  logic [TOG_W-1:0]   tog_r, tog_nxt;
  logic [DIV20_W-1:0] div20_r, div20_nxt;
  logic               level_r, level_nxt;
  logic               dir_r, dir_nxt;
  logic [PROD_W-1:0]  prod;
  logic               hit;

  // negative threshold means a frame time of zero
  assign prod = e1_r * div20_r;
  assign hit  = (tog_r != '0) && (thr[THR_W-1] || (prod >= PROD_W'(thr[SUM_W-1:0])));

  // tick toggling and frame loads
  always_comb begin
    e1_nxt    = e1_r;
    tog_nxt   = tog_r;
    div20_nxt = div20_r;
    level_nxt = level_r;
    dir_nxt   = dir_r;
    if (tick) begin
      if (hit) begin
        e1_nxt    = TIME_W'(1);
        level_nxt = ~level_r;
        if (level_r) begin
          tog_nxt = tog_r - 1'b1;
        end
      end else begin
        e1_nxt = e1_r + 1'b1;
      end
    end
    if (load) begin
      tog_nxt   = load_val.toggles;
      div20_nxt = load_val.div20;
      dir_nxt   = load_val.dir;
    end
  end

  assign axis_out.step = level_nxt;
  assign axis_out.dir  = dir_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e1_r    <= TIME_W'(1);
      tog_r   <= '0;
      div20_r <= '0;
      level_r <= 1'b0;
      dir_r   <= 1'b0;
    end else begin
      e1_r    <= e1_nxt;
      tog_r   <= tog_nxt;
      div20_r <= div20_nxt;
      level_r <= level_nxt;
      dir_r   <= dir_nxt;
    end
  end

endmodule

// File: rtl/framed_position_to_stepper_pulses.sv
// framed_position_to_stepper_pulses: top level with stream ports, input and result registers
// and the register port; instantiates fpsp_frame and one fpsp_axis per axis
// depends on fpsp_pkg, fpsp_frame, fpsp_axis
//
//  channel | direction | handshake            | payload
//  in_     | in        | in_tvalid/in_tready  | tdata data_byte, tuser kind
//  out_    | out       | out_tvalid/out_tready| tdata step x y z, dir x y z, frame_done
//  cfg_    | in        | psel/penable, pready | speed_limit at 0, initial_interval at 4
//
//  one item per cycle while out_tready does not stall the result; a taken item is held in
//  the input register, passes the per-axis threshold multiply and is captured in
//  the result register; state is updated in the same cycle the result is formed
//  reset is synchronous on rst_n low, with no clearing pass
//  a stalled result holds in the result register while the input register takes one more item
module framed_position_to_stepper_pulses import fpsp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,    // [7:0] data_byte
  input  logic                  in_tuser,    // [0] kind
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,   // [0] step_x [1] step_y [2] step_z [3] dir_x
                                             // [4] dir_y [5] dir_z [6] frame_done [7] zero
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  logic                  in_valid_r;
  kind_t                 in_kind_r;
  logic [BYTE_W-1:0]     in_byte_r;
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic [SPEED_W-1:0]    speed_r;
  logic [TIME_W-1:0]     interval_r;

  logic       advance, tick, byte_valid;
  logic       cfg_wr, interval_wr, frame_done;
  reg_sel_t   reg_sel;
  logic [THR_W-1:0] thr;
  axis_load_t [NUM_AXES-1:0] axis_load;
  axis_out_t  [NUM_AXES-1:0] axis_out;

  // pipeline handshake
  assign advance    = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready  = !in_valid_r || advance;
  assign tick       = advance && (in_kind_r == KIND_TICK);
  assign byte_valid = advance && (in_kind_r == KIND_BYTE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_kind_r <= kind_t'(in_tuser);
      in_byte_r <= in_tdata;
    end
  end

  // register port
  assign cfg_pready  = 1'b1;
  assign cfg_wr      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_sel     = reg_sel_t'(cfg_paddr[2]);
  assign interval_wr = cfg_wr && (reg_sel == REG_INITIAL_INTERVAL);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_r    <= SPEED_RESET;
      interval_r <= INTERVAL_RESET;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_SPEED_LIMIT:      speed_r    <= cfg_pwdata[SPEED_W-1:0];
        REG_INITIAL_INTERVAL: interval_r <= cfg_pwdata[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_SPEED_LIMIT:      cfg_prdata = CFG_DATA_W'(speed_r);
      REG_INITIAL_INTERVAL: cfg_prdata = CFG_DATA_W'(interval_r);
      default:              cfg_prdata = '0;
    endcase
  end

  // frame parser and averaging
  fpsp_frame u_frame (
    .clk            (clk),
    .rst_n          (rst_n),
    .byte_valid     (byte_valid),
    .tick           (tick),
    .data_byte      (in_byte_r),
    .speed_limit    (speed_r),
    .interval_wr    (interval_wr),
    .interval_value (cfg_pwdata[TIME_W-1:0]),
    .frame_done     (frame_done),
    .axis_load      (axis_load),
    .thr            (thr)
  );

  // one step timer per axis
  for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
    fpsp_axis u_axis (
      .clk      (clk),
      .rst_n    (rst_n),
      .tick     (tick),
      .load     (frame_done),
      .load_val (axis_load[a]),
      .thr      (thr),
      .axis_out (axis_out[a])
    );
  end

  // result packing
  always_comb begin
    out_data_nxt = '0;
    for (int a = 0; a < NUM_AXES; a++) begin
      out_data_nxt[a]            = axis_out[a].step;
      out_data_nxt[NUM_AXES + a] = axis_out[a].dir;
    end
    out_data_nxt[DONE_BIT] = frame_done;
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

// File: rtl/fpsp_checker.sv
// fpsp_checker: port-level checks of the stepper pulse block, bound to the top level
// watches the stream ports only
// depends on fpsp_pkg and framed_position_to_stepper_pulses
module fpsp_checker import fpsp_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  logic [DONE_BIT-1:0] prev_out_r;
  logic                out_acc;

  assign out_acc = out_tvalid && out_tready;

  // levels of the last delivered item, reset levels before any
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_out_r <= '0;
    end else if (out_acc) begin
      prev_out_r <= out_tdata[DONE_BIT-1:0];
    end
  end

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // input stalls only behind a stalled result
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without output backpressure");

  // a completed frame never toggles a step line
  a_frame_steps: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && out_tdata[DONE_BIT] |->
      out_tdata[NUM_AXES-1:0] == prev_out_r[NUM_AXES-1:0])
    else $error("step level changed on a frame item");

  // directions change only on a completed frame
  a_dir_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && !out_tdata[DONE_BIT] |->
      out_tdata[DONE_BIT-1:NUM_AXES] == prev_out_r[DONE_BIT-1:NUM_AXES])
    else $error("direction changed without a frame");

endmodule

bind framed_position_to_stepper_pulses fpsp_checker u_fpsp_checker (.*);
